>>> src/rbb_pkg.sv
// Shared types, constants and helpers of the RGBA box blur unit.
// Used by rbb_front, rbb_cmd_queue, rbb_back and rgba_box_blur_unit.
package rbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 3;
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;

  localparam int RAD_W  = 2;
  localparam int DIM_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SLOT_W = $clog2(STORE_ROWS);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int LAG_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int SUM_W  = $clog2(STORE_ROWS * STORE_ROWS * 255 + 1);
  localparam int AREA_W = $clog2(STORE_ROWS * STORE_ROWS + 1);
  localparam int PIX_W  = 32;
  localparam int CH_W   = 8;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [RAD_W-1:0] RST_RADIUS = 2'd1;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic              do_write;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  pixel;
    logic              do_emit;
    logic              interior;
    logic              frame_end;
    logic [RAD_W-1:0]  radius;
    logic [SLOT_W-1:0] base_slot;
    logic [COL_W-1:0]  col0;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_DIV,
    BK_EMIT
  } bk_state_e;

  function automatic logic [AREA_W-1:0] win_area(input logic [RAD_W-1:0] r);
    logic [AREA_W-1:0] a;
    a = AREA_W'((2 * r + 1) * (2 * r + 1));
    return a;
  endfunction

endpackage

>>> src/rbb_front.sv
// Front end: accepts items, tracks frame positions and turns each item into
// a store write and/or an output command. Depends on rbb_pkg.
module rbb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbb_pkg::cfg_t      cfg_i,
  input  logic               restart_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [31:0]        pixel_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rbb_pkg::cmd_t      q_data_o,
  output logic               at_start_o
);
  import rbb_pkg::*;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [CNT_W-1:0]  frame_n, lag_full;
  logic [LAG_W-1:0]  lag;
  logic [COL_W-1:0]  col_q, ocol_q;
  logic [ROW_W-1:0]  orow_q;
  logic [SLOT_W-1:0] rslot_q, oslot_q;
  logic [CNT_W-1:0]  in_cnt_q, emitted_q;
  logic              accept, full_in, do_write, do_emit, last_out, interior;
  logic [CNT_W-1:0]  pend;
  logic [DIM_W-1:0]  oy_ext, ox_ext, r_ext;
  logic [SLOT_W:0]   base_tmp;

  // frame size and output lag follow the registers at once
  always_comb begin
    if (cfg_i.width == '0) w_eff = DIM_W'(1);
    else if (cfg_i.width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = cfg_i.width;
    if (cfg_i.height == '0) h_eff = DIM_W'(1);
    else if (cfg_i.height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = cfg_i.height;
    lag_full = CNT_W'(cfg_i.radius) * CNT_W'(w_eff) + CNT_W'(cfg_i.radius);
    lag      = lag_full[LAG_W-1:0];
    frame_n  = CNT_W'(w_eff) * CNT_W'(h_eff);
  end

  assign accept   = in_valid_i && !q_full_i;
  assign full_in  = in_cnt_q >= frame_n;
  assign do_write = (operation_i == OP_PIXEL) && !full_in;
  assign pend     = in_cnt_q + CNT_W'(1) - emitted_q;
  assign last_out = (emitted_q + CNT_W'(1)) == frame_n;

  always_comb begin
    if (operation_i == OP_PIXEL)
      do_emit = do_write && (emitted_q < frame_n) && (pend > CNT_W'(lag));
    else
      do_emit = full_in && (emitted_q < frame_n);
  end

  assign oy_ext   = DIM_W'(orow_q);
  assign ox_ext   = DIM_W'(ocol_q);
  assign r_ext    = DIM_W'(cfg_i.radius);
  assign interior = (oy_ext >= r_ext) && (oy_ext + r_ext < h_eff) &&
                    (ox_ext >= r_ext) && (ox_ext + r_ext < w_eff);
  assign base_tmp = {1'b0, oslot_q} + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(cfg_i.radius);

  always_comb begin
    q_data_o.do_write  = do_write;
    q_data_o.waddr     = {rslot_q, col_q};
    q_data_o.pixel     = pixel_i;
    q_data_o.do_emit   = do_emit;
    q_data_o.interior  = interior;
    q_data_o.frame_end = last_out;
    q_data_o.radius    = cfg_i.radius;
    q_data_o.base_slot = (base_tmp >= (SLOT_W+1)'(STORE_ROWS)) ?
                         SLOT_W'(base_tmp - (SLOT_W+1)'(STORE_ROWS)) : base_tmp[SLOT_W-1:0];
    q_data_o.col0      = ocol_q - COL_W'(cfg_i.radius);
  end

  assign q_push_o   = accept && (do_write || do_emit);
  assign in_stall_o = q_full_i;
  assign at_start_o = (in_cnt_q == '0) && (emitted_q == '0) && (col_q == '0) &&
                      (ocol_q == '0) && (orow_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      rslot_q   <= '0;
      in_cnt_q  <= '0;
      emitted_q <= '0;
      ocol_q    <= '0;
      orow_q    <= '0;
      oslot_q   <= '0;
    end else if (restart_i) begin
      col_q     <= '0;
      rslot_q   <= '0;
      in_cnt_q  <= '0;
      emitted_q <= '0;
      ocol_q    <= '0;
      orow_q    <= '0;
      oslot_q   <= '0;
    end else if (accept) begin
      if (do_write) begin
        in_cnt_q <= in_cnt_q + CNT_W'(1);
        if (DIM_W'(col_q) + DIM_W'(1) == w_eff) begin
          col_q   <= '0;
          rslot_q <= (rslot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : rslot_q + SLOT_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (do_emit) begin
        if (last_out) begin
          col_q     <= '0;
          rslot_q   <= '0;
          in_cnt_q  <= '0;
          emitted_q <= '0;
          ocol_q    <= '0;
          orow_q    <= '0;
          oslot_q   <= '0;
        end else begin
          emitted_q <= emitted_q + CNT_W'(1);
          if (DIM_W'(ocol_q) + DIM_W'(1) == w_eff) begin
            ocol_q  <= '0;
            orow_q  <= orow_q + ROW_W'(1);
            oslot_q <= (oslot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : oslot_q + SLOT_W'(1);
          end else begin
            ocol_q <= ocol_q + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

>>> src/rbb_cmd_queue.sv
// Short command queue between front end and back end.
// Depends on rbb_pkg.
module rbb_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbb_pkg::cmd_t data_i,
  input  logic          pop_i,
  output rbb_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import rbb_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = count_q == (QPTR_W+1)'(QDEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) entry_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i && !full_o) wptr_q <= wptr_q + QPTR_W'(1);
      if (pop_i && !empty_o) rptr_q <= rptr_q + QPTR_W'(1);
      count_q <= count_q + (QPTR_W+1)'(push_i && !full_o) - (QPTR_W+1)'(pop_i && !empty_o);
    end
  end

endmodule

>>> src/rbb_back.sv
// Back end: owns the row store, writes pixels, sums the window one pixel a
// cycle, divides by the window area bit-serially and holds the result word.
// Depends on rbb_pkg.
module rbb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rbb_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   out_pixel_o,
  output logic          out_frame_end_o
);
  import rbb_pkg::*;

  logic [PIX_W-1:0]  store_mem [STORE_ROWS * MAX_WIDTH];
  bk_state_e         state_q, state_d;
  logic [PIX_W-1:0]  rdata_q;
  logic              rd_v_q, issue, load_out, last_rd;
  logic [RAD_W-1:0]  radius_q;
  logic              fend_q;
  logic [COL_W-1:0]  col0_q, cx_q;
  logic [SLOT_W-1:0] rs_q;
  logic [2:0]        dx_q, dy_q, side_m1, step_q;
  logic [SUM_W-1:0]  sum_q [4];
  logic [CH_W-1:0]   quo_q [4];
  logic [SUM_W-1:0]  trial;
  logic              out_v_q, fend_out_q;
  logic [PIX_W-1:0]  out_pix_q;

  assign side_m1 = {radius_q, 1'b0};
  assign last_rd = (dx_q == side_m1) && (dy_q == side_m1);
  assign trial   = SUM_W'(win_area(radius_q)) << step_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!q_empty_i && q_data_i.do_emit)
                 state_d = q_data_i.interior ? BK_READ : BK_EMIT;
      BK_READ: if (last_rd) state_d = BK_WAIT;
      BK_WAIT: state_d = BK_DIV;
      BK_DIV:  if (step_q == '0) state_d = BK_EMIT;
      BK_EMIT: if (!out_v_q || !out_stall_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: q_pop_o  = !q_empty_i;
      BK_READ: issue    = 1'b1;
      BK_EMIT: load_out = !out_v_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.do_write) store_mem[q_data_i.waddr] <= q_data_i.pixel;
    if (issue) rdata_q <= store_mem[{rs_q, cx_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      if (load_out) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.do_emit) begin
      radius_q <= q_data_i.radius;
      fend_q   <= q_data_i.frame_end;
      col0_q   <= q_data_i.col0;
      cx_q     <= q_data_i.col0;
      rs_q     <= q_data_i.base_slot;
      dx_q     <= '0;
      dy_q     <= '0;
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= '0;
        quo_q[c] <= '0;
      end
    end
    if (issue) begin
      if (dx_q == side_m1) begin
        dx_q <= '0;
        cx_q <= col0_q;
        dy_q <= dy_q + 3'd1;
        rs_q <= (rs_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : rs_q + SLOT_W'(1);
      end else begin
        dx_q <= dx_q + 3'd1;
        cx_q <= cx_q + COL_W'(1);
      end
    end
    if (rd_v_q) begin
      for (int c = 0; c < 4; c++)
        sum_q[c] <= sum_q[c] + SUM_W'(rdata_q[CH_W*c +: CH_W]);
    end
    if (state_q == BK_WAIT) step_q <= 3'd7;
    // restoring division, one quotient bit per cycle, MSB first
    if (state_q == BK_DIV) begin
      step_q <= step_q - 3'd1;
      for (int c = 0; c < 4; c++) begin
        if (sum_q[c] >= trial) begin
          sum_q[c] <= sum_q[c] - trial;
          quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b0};
        end
      end
    end
    if (load_out) begin
      out_pix_q  <= {quo_q[3], quo_q[2], quo_q[1], quo_q[0]};
      fend_out_q <= fend_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_pixel_o     = out_pix_q;
  assign out_frame_end_o = fend_out_q;

endmodule

>>> src/rgba_box_blur_unit.sv
// RGBA box blur unit: register port, front end, command queue, back end.
// Depends on rbb_pkg, rbb_front, rbb_cmd_queue and rbb_back.
//
// Pixels arrive in raster order and each result word is the per-channel
// floor average over a (2r+1)x(2r+1) window, zero within r of an edge. A
// result trails its pixel by r rows plus r pixels; drain items flush the tail
// of a frame. The front end takes one item per cycle while the 4-entry
// command queue has room. For an interior result the back end reads the
// window from the single-port row store one pixel per cycle, then divides
// bit-serially; a border result or a pixel that yields no result needs
// neither. The back end pops a new command only when done with the current
// one. Writes to the radius, width or height register restart the frame.
module rgba_box_blur_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbb_pkg::PADDR_W-1:0] paddr,
  input  logic [rbb_pkg::PDATA_W-1:0] pwdata,
  output logic [rbb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [7:0]                  in_blue_i,
  input  logic [7:0]                  in_green_i,
  input  logic [7:0]                  in_red_i,
  input  logic [7:0]                  in_alpha_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_blue_o,
  output logic [7:0]                  out_green_o,
  output logic [7:0]                  out_red_o,
  output logic [7:0]                  out_alpha_o,
  output logic                        frame_end_o
);
  import rbb_pkg::*;

  cfg_t        cfg_q;
  logic        cfg_wr, restart;
  logic [1:0]  reg_idx;
  cmd_t        push_data, head_data;
  logic        q_push, q_full, q_pop, q_empty;
  logic        at_start;
  logic [31:0] out_pix;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius <= RST_RADIUS;
      cfg_q.width  <= RST_WIDTH;
      cfg_q.height <= RST_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RADIUS: cfg_q.radius <= pwdata[RAD_W-1:0];
        REG_WIDTH:  cfg_q.width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_q.height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    unique case (reg_idx)
      REG_RADIUS: begin
        prdata  = PDATA_W'(cfg_q.radius);
        restart = cfg_wr;
      end
      REG_WIDTH: begin
        prdata  = PDATA_W'(cfg_q.width);
        restart = cfg_wr;
      end
      REG_HEIGHT: begin
        prdata  = PDATA_W'(cfg_q.height);
        restart = cfg_wr;
      end
      default: ;
    endcase
  end

  rbb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .pixel_i    ({in_alpha_i, in_red_i, in_green_i, in_blue_i}),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (push_data),
    .at_start_o (at_start)
  );

  rbb_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (push_data),
    .pop_i  (q_pop),
    .data_o (head_data),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  rbb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (head_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_pixel_o    (out_pix),
    .out_frame_end_o(frame_end_o)
  );

  assign out_blue_o  = out_pix[7:0];
  assign out_green_o = out_pix[15:8];
  assign out_red_o   = out_pix[23:16];
  assign out_alpha_o = out_pix[31:24];

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("command popped from empty queue");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> at_start) else $error("frame not restarted after register write");

endmodule
